### rtl/ers_pkg.sv
// Shared types and constants for the enumeration rank sorter.
// No dependencies; imported by every rtl module of the block except ers_ram.
package ers_pkg;

	localparam int Depth     = 64;                          // keys per set
	localparam int KeyW      = 32;                          // key width, unsigned UQ1.31
	localparam int IdxW      = $clog2(Depth);               // position / rank width
	localparam int CntW      = $clog2(Depth + 1);           // key count width
	localparam int GrpSize   = 8;                           // compare bits per count group
	localparam int NGrp      = (Depth + GrpSize - 1) / GrpSize;
	localparam int GrpCntW   = $clog2(GrpSize + 1);

	typedef enum logic [2:0] {
		ST_IDLE,   // waiting for a key
		ST_RANK,   // folding the registered compare result into the cells
		ST_SWEEP,  // shifting cells out into the sorted memory
		ST_READ,   // reading one sorted position
		ST_LOAD,   // loading the output register
		ST_SHOW    // result on the output, waiting for transfer
	} ers_state_t;

	typedef struct packed {
		logic load;    // capture key and compare vectors
		logic update;  // insert key, bump ranks of larger keys
		logic sweep;   // shift one cell into the sorted memory
		logic rd;      // read sorted memory at current position
		logic show;    // load output register
		logic done;    // output transfer this cycle
	} ers_cmd_t;

	typedef struct packed {
		logic last_s1;     // captured key closes the set
		logic sweep_last;  // final cell of the sweep
		logic pos_last;    // current position is the last of the set
	} ers_stat_t;

endpackage

### rtl/enumeration_rank_sort.sv
// Top level of the enumeration rank sorter: controller plus datapath.
// Depends on ers_pkg, ers_ctrl, ers_dp (and ers_ram through ers_dp).
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   in       | in_valid / in_stall | key[31:0], last
//   out      | out_valid/out_stall | value[31:0], filled, end_of_set, overflow
//
// For each key, the transfer cycle registers the key and its compare
// vectors against every stored cell; the next cycle adds up the per-group
// counts into the new key's rank and bumps the rank of each larger stored
// key. in_stall is high during that rank step.
// After the key marked last, the cells of all keys held shift one by one
// into the sorted memory, then each result passes through memory read,
// output load and transfer; out_stall extends the transfer.
// arst_n clears the sequencer, key count, overflow mark and slot flags;
// no clearing pass is needed.
module enumeration_rank_sort import ers_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [KeyW-1:0] key,
	input  logic            last,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [KeyW-1:0] value,
	output logic            filled,
	output logic            end_of_set,
	output logic            overflow
);

	ers_cmd_t  cmd;
	ers_stat_t stat;

	// sequencer: decides which datapath step runs each cycle
	ers_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// cells, rank counters, sorted memory and output register
	ers_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.key        (key),
		.last       (last),
		.value      (value),
		.filled     (filled),
		.end_of_set (end_of_set),
		.overflow   (overflow)
	);

endmodule

### rtl/ers_ram.sv
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module ers_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/ers_ctrl.sv
// Sequencer for the rank sorter: load, rank, sweep and result phases.
// Depends on ers_pkg.
module ers_ctrl import ers_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  ers_stat_t stat,
	output ers_cmd_t  cmd
);

	ers_state_t state_q;
	ers_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RANK;
			end
			ST_RANK: begin
				state_d = stat.last_s1 ? ST_SWEEP : ST_IDLE;
			end
			ST_SWEEP: begin
				if (stat.sweep_last) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (!out_stall) state_d = stat.pos_last ? ST_IDLE : ST_READ;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_RANK: begin
				cmd.update = 1'b1;
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
			end
			ST_LOAD: begin
				cmd.show = 1'b1;
			end
			ST_SHOW: begin
				out_valid = 1'b1;
				cmd.done  = !out_stall;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/ers_dp.sv
// Datapath of the rank sorter: comparator cells, rank counters, sorted
// memory and output register. Depends on ers_pkg and ers_ram.
module ers_dp import ers_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  ers_cmd_t        cmd,
	output ers_stat_t       stat,
	input  logic [KeyW-1:0] key,
	input  logic            last,
	output logic [KeyW-1:0] value,
	output logic            filled,
	output logic            end_of_set,
	output logic            overflow
);

	// comparator cells, in arrival order
	logic [KeyW-1:0] key_q  [Depth];
	logic [IdxW-1:0] rank_q [Depth];
	logic [KeyW-1:0] nxt_key  [Depth];
	logic [IdxW-1:0] nxt_rank [Depth];

	logic [CntW-1:0] cnt_q;
	logic            drop_q;
	logic [Depth-1:0] fill_q;
	logic [IdxW-1:0] swp_q;
	logic [IdxW-1:0] pos_q;

	// compare stage
	logic [KeyW-1:0]       key_s1;
	logic                  last_s1;
	logic [Depth-1:0]      gt_s1;
	logic [GrpCntW-1:0]    grp_s1 [NGrp];
	logic [Depth-1:0]      lt_vec;
	logic [Depth-1:0]      gt_vec;
	logic [NGrp*GrpSize-1:0] lt_pad;
	logic [GrpCntW-1:0]    grp_cnt [NGrp];

	logic [CntW-1:0] rank_sum;
	logic [IdxW-1:0] rank_new;
	logic            full;
	logic [CntW-1:0] cnt_m1;

	logic [KeyW-1:0] ram_rdata;

	logic [KeyW-1:0] value_q;
	logic            fill_out_q;
	logic            eos_q;
	logic            ovf_q;

	assign full   = (cnt_q == CntW'(Depth));
	assign cnt_m1 = cnt_q - CntW'(1);

	always_comb begin
		for (int i = 0; i < Depth; i++) begin
			lt_vec[i] = (CntW'(i) < cnt_q) && (key_q[i] < key);
			gt_vec[i] = (CntW'(i) < cnt_q) && (key_q[i] > key);
		end
	end

	assign lt_pad = (NGrp*GrpSize)'(lt_vec);

	always_comb begin
		for (int g = 0; g < NGrp; g++) begin
			grp_cnt[g] = '0;
			for (int b = 0; b < GrpSize; b++) begin
				grp_cnt[g] = grp_cnt[g] + GrpCntW'(lt_pad[g*GrpSize + b]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_s1  <= key;
			last_s1 <= last;
			gt_s1   <= gt_vec;
			for (int g = 0; g < NGrp; g++) begin
				grp_s1[g] <= grp_cnt[g];
			end
		end
	end

	always_comb begin
		rank_sum = '0;
		for (int g = 0; g < NGrp; g++) begin
			rank_sum = rank_sum + CntW'(grp_s1[g]);
		end
	end

	assign rank_new = rank_sum[IdxW-1:0];

	// cells: shift toward cell 0 during the sweep, insert at cnt_q on update unless full
	for (genvar gi = 0; gi < Depth; gi++) begin : g_cell
		if (gi < Depth - 1) begin : g_mid
			assign nxt_key[gi]  = key_q[gi+1];
			assign nxt_rank[gi] = rank_q[gi+1];
		end else begin : g_end
			assign nxt_key[gi]  = key_q[gi];
			assign nxt_rank[gi] = rank_q[gi];
		end

		always_ff @(posedge clk) begin
			if (cmd.sweep) begin
				key_q[gi]  <= nxt_key[gi];
				rank_q[gi] <= nxt_rank[gi];
			end else if (cmd.update && !full) begin
				if (cnt_q == CntW'(gi)) begin
					key_q[gi]  <= key_s1;
					rank_q[gi] <= rank_new;
				end else if (gt_s1[gi]) begin
					rank_q[gi] <= rank_q[gi] + IdxW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
			fill_q <= '0;
			swp_q  <= '0;
			pos_q  <= '0;
		end else begin
			if (cmd.update) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CntW'(1);
				end
			end
			if (cmd.sweep) begin
				fill_q[rank_q[0]] <= 1'b1;
				swp_q             <= swp_q + IdxW'(1);
			end
			if (cmd.done) begin
				if (stat.pos_last) begin
					cnt_q  <= '0;
					drop_q <= 1'b0;
					fill_q <= '0;
					swp_q  <= '0;
					pos_q  <= '0;
				end else begin
					pos_q <= pos_q + IdxW'(1);
				end
			end
		end
	end

	ers_ram #(
		.WIDTH (KeyW),
		.DEPTH (Depth)
	) u_sorted (
		.clk   (clk),
		.we    (cmd.sweep),
		.waddr (rank_q[0]),
		.wdata (key_q[0]),
		.re    (cmd.rd),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.show) begin
			value_q    <= fill_q[pos_q] ? ram_rdata : '0;
			fill_out_q <= fill_q[pos_q];
			eos_q      <= stat.pos_last;
			ovf_q      <= drop_q;
		end
	end

	assign stat.last_s1    = last_s1;
	assign stat.sweep_last = (CntW'(swp_q) == cnt_m1);
	assign stat.pos_last   = (CntW'(pos_q) == cnt_m1);

	assign value      = value_q;
	assign filled     = fill_out_q;
	assign end_of_set = eos_q;
	assign overflow   = ovf_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("key count above capacity");

	a_drop_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && full) |=> drop_q)
		else $error("key dropped without overflow mark");

	a_sweep_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> (cnt_q != '0))
		else $error("sweep with empty set");

	a_gap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.show) && !fill_out_q |-> (value_q == '0))
		else $error("unfilled position carries a key");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for enumeration_rank_sort: streams sets of keys,
// predicts every sorted position and checks each output transfer against it.
// Depends on ers_pkg and the rtl of the block; reads no files.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ers_pkg::*;

	localparam int ClkPeriod      = 10;
	localparam int ResetCycles    = 5;
	localparam int RandomItems    = 312;
	localparam int HoldOffCycles  = 400;     // one long receiver hold-off
	localparam int HoldOffAt      = 30;      // ...after this many output transfers
	localparam int DrainCycles    = 2 * Depth + 20;
	localparam int TimeoutCycles  = 200_000;
	localparam int MaxPrinted     = 100;     // cap on printed mismatch lines

	// One sorted position as it leaves the block.
	typedef struct packed {
		logic [KeyW-1:0] value;
		logic            filled;
		logic            end_of_set;
		logic            overflow;
	} sorted_pos_t;

	// How the keys of a random set are drawn.
	typedef enum int {
		KEYS_WIDE,    // any 32-bit value
		KEYS_POOL,    // few distinct values, many ties
		KEYS_NARROW,  // 0..7, ties and neighbors
		KEYS_EDGE     // mostly range ends and the midpoint
	} key_mix_t;

	// Rank predictor plus the queue of sorted positions still owed by the block.
	class sort_scoreboard;
		logic [KeyW-1:0] loaded[Depth];
		int unsigned     n_loaded = 0;
		bit              dropped = 1'b0;
		sorted_pos_t     expected_q[$];
		int unsigned     pos_idx = 0;
		int unsigned     errors = 0;
		int unsigned     positions_checked = 0;
		int unsigned     sets_closed = 0;
		int unsigned     overflow_sets = 0;
		int unsigned     keys_taken = 0;

		// Accepted input transfer; a key marked last closes the set.
		function void note_key(logic [KeyW-1:0] k, logic is_last);
			logic [KeyW-1:0] by_rank[Depth];
			bit              taken[Depth];
			int unsigned     rank;
			sorted_pos_t     r;
			keys_taken++;
			if (n_loaded < Depth) begin
				loaded[n_loaded] = k;
				n_loaded++;
			end else begin
				dropped = 1'b1;
			end
			if (!is_last)
				return;
			for (int p = 0; p < Depth; p++)
				taken[p] = 1'b0;
			// rank = number of strictly smaller keys; ties collide on one slot
			for (int j = 0; j < n_loaded; j++) begin
				rank = 0;
				for (int i = 0; i < n_loaded; i++)
					if (loaded[i] < loaded[j])
						rank++;
				by_rank[rank] = loaded[j];
				taken[rank]   = 1'b1;
			end
			for (int p = 0; p < n_loaded; p++) begin
				r.value      = taken[p] ? by_rank[p] : '0;
				r.filled     = taken[p];
				r.end_of_set = (p == n_loaded - 1);
				r.overflow   = dropped;
				expected_q.push_back(r);
			end
			sets_closed++;
			if (dropped)
				overflow_sets++;
			n_loaded = 0;
			dropped  = 1'b0;
		endfunction

		// Accepted output transfer against the oldest owed position.
		task check_result(sorted_pos_t got);
			sorted_pos_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result: value %h filled %b end %b ovf %b",
					got.value, got.filled, got.end_of_set, got.overflow));
				return;
			end
			want = expected_q.pop_front();
			positions_checked++;
			if (got.value !== want.value)
				report($sformatf("pos %0d value %h, want %h", pos_idx, got.value, want.value));
			if (got.filled !== want.filled)
				report($sformatf("pos %0d filled %b, want %b", pos_idx, got.filled,
					want.filled));
			if (got.end_of_set !== want.end_of_set)
				report($sformatf("pos %0d end_of_set %b, want %b", pos_idx,
					got.end_of_set, want.end_of_set));
			if (got.overflow !== want.overflow)
				report($sformatf("pos %0d overflow %b, want %b", pos_idx, got.overflow,
					want.overflow));
			pos_idx = want.end_of_set ? 0 : pos_idx + 1;
		endtask

		task report(string msg);
			errors++;
			if (errors <= MaxPrinted)
				$display("ERROR @%0t: %s", $time, msg);
		endtask
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic [KeyW-1:0] key = '0;
	logic            last = 1'b0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic [KeyW-1:0] value;
	logic            filled;
	logic            end_of_set;
	logic            overflow;

	sort_scoreboard  sb = new;
	bit              sender_quick = 1'b0;   // set: no gaps between input transfers
	int unsigned     items_sent = 0;

	always #(ClkPeriod / 2) clk = ~clk;

	enumeration_rank_sort u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key        (key),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.filled     (filled),
		.end_of_set (end_of_set),
		.overflow   (overflow)
	);

	// Output monitor: everything is sampled at the edge, before the NBA updates,
	// so a transfer is exactly valid high and stall low at that edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(sorted_pos_t'{value, filled, end_of_set, overflow});
	end

	// Offer one key, hold it until the transfer, then tell the predictor.
	// valid stays high across back-to-back keys (no drop-and-raise in one step).
	task automatic send_key(input logic [KeyW-1:0] k, input logic is_last);
		int unsigned gap;
		gap = sender_quick ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key      <= k;
		last     <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_key(k, is_last);
		items_sent++;
	endtask

	// One set of n_keys keys, the final one marked last. Past Depth keys the
	// block drops the rest, the last-marked key included.
	task automatic send_random_set(input int unsigned n_keys);
		logic [KeyW-1:0] pool[4];
		logic [KeyW-1:0] k;
		key_mix_t        mix;
		mix = key_mix_t'($urandom_range(0, 3));
		foreach (pool[i])
			pool[i] = $urandom;
		sender_quick = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n_keys; i++) begin
			case (mix)
				KEYS_WIDE:   k = $urandom;
				KEYS_POOL:   k = pool[$urandom_range(0, 3)];
				KEYS_NARROW: k = $urandom_range(0, 7);
				default: begin
					case ($urandom_range(0, 4))
						0:       k = '0;
						1:       k = '1;
						2:       k = 32'h8000_0000;
						3:       k = 32'h7FFF_FFFF;
						default: k = $urandom;
					endcase
				end
			endcase
			send_key(k, i == n_keys - 1);
		end
	endtask

	// Input side: reset, directed sets, random sets, then drain and verdict.
	initial begin
		int unsigned directed_end;
		int unsigned set_no;
		int unsigned set_len;
		// driven after time zero starts so the flops see the falling edge
		arst_n <= 1'b0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single key set
		send_key(32'h0000_0000, 1'b1);
		// range ends and both sides of the midpoint, out of order
		send_key(32'hFFFF_FFFF, 1'b0);
		send_key(32'h0000_0000, 1'b0);
		send_key(32'h8000_0000, 1'b0);
		send_key(32'h7FFF_FFFF, 1'b1);
		// three equal keys over a smaller one: two unfilled gaps at the top
		send_key(32'd5, 1'b0);
		send_key(32'd5, 1'b0);
		send_key(32'd5, 1'b0);
		send_key(32'd1, 1'b1);
		// all keys equal at full scale
		send_key(32'hFFFF_FFFF, 1'b0);
		send_key(32'hFFFF_FFFF, 1'b1);
		// already sorted, then reverse sorted
		send_key(32'h0000_0010, 1'b0);
		send_key(32'h0000_0020, 1'b0);
		send_key(32'h0000_0030, 1'b0);
		send_key(32'h0000_0040, 1'b1);
		send_key(32'd9, 1'b0);
		send_key(32'd8, 1'b0);
		send_key(32'd7, 1'b1);
		directed_end = items_sent;

		// mostly short sets; a few long ones, an exactly full set and two
		// sets that overrun capacity (one by only the last-marked key)
		set_no = 0;
		while (items_sent < directed_end + RandomItems) begin
			case (set_no)
				2:       set_len = Depth;
				5:       set_len = Depth + 3;
				9:       set_len = Depth + 1;
				default: set_len = ($urandom_range(0, 7) == 0) ?
					$urandom_range(11, Depth) : $urandom_range(1, 10);
			endcase
			send_random_set(set_len);
			set_no++;
		end
		in_valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d sets (%0d with dropped keys) from %0d keys;",
			sb.sets_closed, sb.overflow_sets, sb.keys_taken);
		$display("checked %0d sorted positions, %0d field errors",
			sb.positions_checked, sb.errors);
		if (sb.errors == 0)
			$display("enumeration_rank_sort: match");
		else
			$display("enumeration_rank_sort: mismatch");
		$finish;
	end

	// Output side: random stall before each transfer, bursts with none, and
	// one long hold-off so the block backs up and stalls its input.
	initial begin
		int unsigned hold;
		int unsigned transfers;
		bit          recv_quick;
		bit          held_off;
		transfers  = 0;
		recv_quick = 1'b0;
		held_off   = 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (transfers % 16 == 0)
				recv_quick = ($urandom_range(0, 2) == 0);
			hold = recv_quick ? 0 : $urandom_range(0, 5);
			if (!held_off && transfers == HoldOffAt) begin
				hold     = HoldOffCycles;
				held_off = 1'b1;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			transfers++;
		end
	end

	// Watchdog: generous bound well past the slowest legal run.
	initial begin
		#(TimeoutCycles * ClkPeriod);
		$display("timeout: %0d sorted positions still owed", sb.expected_q.size());
		$display("enumeration_rank_sort: mismatch");
		$finish;
	end

endmodule
